@@ hdl/olad_pkg.sv @@
// Shared types and codes for the ordered list block.
package olad_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4
    } t_status;

    // Source of the emitted item value.
    typedef enum logic [1:0] {
        SRC_IN  = 2'd0,
        SRC_VAL = 2'd1,
        SRC_MEM = 2'd2
    } t_src;

    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_next;
        logic    wr_append;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    emit;
        t_src    src;
        t_status status;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic idx_last;
        logic shift_last;
    } t_dp_sts;

endpackage

@@ hdl/olad_ctrl.sv @@
// Sequencer for append, delete-with-shift and dump transactions.
module olad_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_cmd,
    input  olad_pkg::t_dp_sts  i_sts,
    output olad_pkg::t_dp_cmd  o_dp,
    output logic               busy
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DEL_RD  = 7'b0000010,
        S_DEL_CMP = 7'b0000100,
        S_SHF_RD  = 7'b0001000,
        S_SHF_WR  = 7'b0010000,
        S_DMP_RD  = 7'b0100000,
        S_DMP_OUT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_dp    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd) inside
                        olad_pkg::CMD_APPEND: begin
                            o_dp.emit = 1'b1;
                            o_dp.src  = olad_pkg::SRC_IN;
                            o_dp.last = 1'b1;
                            if (i_sts.full) begin
                                o_dp.status = olad_pkg::ST_FULL;
                            end else begin
                                o_dp.status    = olad_pkg::ST_DONE;
                                o_dp.wr_append = 1'b1;
                                o_dp.cnt_inc   = 1'b1;
                            end
                        end
                        olad_pkg::CMD_DELETE, olad_pkg::CMD_DUMP: begin
                            if (i_sts.empty) begin
                                o_dp.emit   = 1'b1;
                                o_dp.src    = olad_pkg::SRC_IN;
                                o_dp.status = olad_pkg::ST_EMPTY;
                                o_dp.last   = 1'b1;
                            end else begin
                                o_dp.load    = 1'b1;
                                o_dp.idx_clr = 1'b1;
                                n_state = (i_cmd == olad_pkg::CMD_DELETE) ? S_DEL_RD
                                                                          : S_DMP_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DEL_RD: begin
                n_state = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (i_sts.match) begin
                    if (i_sts.idx_last) begin
                        o_dp.cnt_dec = 1'b1;
                        o_dp.emit    = 1'b1;
                        o_dp.src     = olad_pkg::SRC_VAL;
                        o_dp.status  = olad_pkg::ST_DONE;
                        o_dp.last    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_dp.rd_next = 1'b1;
                        n_state = S_SHF_WR;
                    end
                end else if (i_sts.idx_last) begin
                    o_dp.emit   = 1'b1;
                    o_dp.src    = olad_pkg::SRC_VAL;
                    o_dp.status = olad_pkg::ST_NOT_FOUND;
                    o_dp.last   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_dp.idx_inc = 1'b1;
                    n_state = S_DEL_RD;
                end
            end
            S_SHF_RD: begin
                o_dp.rd_next = 1'b1;
                n_state = S_SHF_WR;
            end
            S_SHF_WR: begin
                o_dp.wr_shift = 1'b1;
                if (i_sts.shift_last) begin
                    o_dp.cnt_dec = 1'b1;
                    o_dp.emit    = 1'b1;
                    o_dp.src     = olad_pkg::SRC_VAL;
                    o_dp.status  = olad_pkg::ST_DONE;
                    o_dp.last    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_dp.idx_inc = 1'b1;
                    n_state = S_SHF_RD;
                end
            end
            S_DMP_RD: begin
                n_state = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                o_dp.emit    = 1'b1;
                o_dp.src     = olad_pkg::SRC_MEM;
                o_dp.status  = olad_pkg::ST_ENTRY;
                o_dp.last    = i_sts.idx_last;
                o_dp.idx_inc = 1'b1;
                n_state = i_sts.idx_last ? S_IDLE : S_DMP_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hdl/olad_dp.sv @@
// Entry memory, count, scan index and registered result outputs.
module olad_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [31:0]        i_value,
    input  olad_pkg::t_dp_cmd         i_dp,
    output olad_pkg::t_dp_sts         o_sts,
    output logic                      o_valid,
    output logic signed [31:0]        o_item_value,
    output logic [2:0]                o_status,
    output logic                      o_last
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [olad_pkg::DataW-1:0] mem [CAPACITY];
    logic [olad_pkg::DataW-1:0] r_rd_data;
    logic [olad_pkg::DataW-1:0] r_value;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_idx;

    logic [CW:0]                idx_p1;
    logic [CW:0]                idx_p2;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              wr_addr;
    logic [olad_pkg::DataW-1:0] wr_data;
    logic                       wr_en;
    logic [olad_pkg::DataW-1:0] item;

    assign idx_p1  = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_p2  = {1'b0, r_idx} + (CW+1)'(2);
    assign rd_addr = i_dp.rd_next ? idx_p1[IW-1:0] : r_idx[IW-1:0];
    assign wr_en   = i_dp.wr_append | i_dp.wr_shift;
    assign wr_addr = i_dp.wr_append ? r_count[IW-1:0] : r_idx[IW-1:0];
    assign wr_data = i_dp.wr_append ? i_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_dp.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.load) begin
            r_value <= i_value;
        end
        if (i_dp.idx_clr) begin
            r_idx <= '0;
        end else if (i_dp.idx_inc) begin
            r_idx <= idx_p1[CW-1:0];
        end
    end

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == CW'(CAPACITY));
    assign o_sts.match      = (r_rd_data == r_value);
    assign o_sts.idx_last   = (idx_p1 == {1'b0, r_count});
    assign o_sts.shift_last = (idx_p2 == {1'b0, r_count});

    always_comb begin
        case (i_dp.src)
            olad_pkg::SRC_VAL: item = r_value;
            olad_pkg::SRC_MEM: item = r_rd_data;
            default:           item = i_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_dp.emit;
        end
        if (i_dp.emit) begin
            o_item_value <= item;
            o_status     <= i_dp.status;
            o_last       <= i_dp.last;
        end
    end

endmodule

@@ hdl/ordered_list_append_delete.sv @@
// Ordered list of signed 32-bit values: append, delete first match, dump.
//
// A transaction is taken when start is high and busy is low; i_cmd picks
// append, delete or dump and i_value carries the operand. Results leave on
// o_item_value / o_status / o_last, each valid for one cycle while o_valid
// is high; the receiver has no way to hold them off. o_last marks the final
// result of a transaction.
// Sequence of each transaction:
//   append: handled in idle without going busy; result registered at accept.
//   delete: each entry is read (S_DEL_RD), then compared (S_DEL_CMP); after a
//           match each later entry is read and written one place down; every
//           compare waits on the entry memory's registered read port.
//   dump:   each entry is read, then emitted (S_DMP_RD, S_DMP_OUT).
//   empty list or full list: single status result, handled in idle.
// busy drops in the cycle the last result is shown, so the next
// transaction may be taken while that result is on the ports.
// Reset empties the list and returns the sequencer to idle; no memory sweep.
module ordered_list_append_delete #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_item_value,
    output logic [2:0]         o_status,
    output logic               o_last
);

    olad_pkg::t_dp_cmd dp_cmd;
    olad_pkg::t_dp_sts dp_sts;

    olad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (dp_sts),
        .o_dp    (dp_cmd),
        .busy    (busy)
    );

    olad_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_dp         (dp_cmd),
        .o_sts        (dp_sts),
        .o_valid      (o_valid),
        .o_item_value (o_item_value),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

@@ sim/ordered_list_append_delete_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list block: directed and random transactions.
module ordered_list_append_delete_test;

    localparam int unsigned LIST_DEPTH = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [31:0]       value;
        olad_pkg::t_status status;
        logic              last;
    } t_list_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_cmd = 2'd0;
    logic signed [31:0] i_value = 32'sd0;
    logic               o_valid;
    logic signed [31:0] o_item_value;
    logic [2:0]         o_status;
    logic               o_last;

    logic [31:0]  held_values[$];
    t_list_result expected_results[$];
    int unsigned  mismatch_cnt = 0;
    int unsigned  stall_cycles = 0;
    bit           sender_idles = 1'b1;

    ordered_list_append_delete #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_item_value(o_item_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void push_result(input logic [31:0] v,
                                        input olad_pkg::t_status st,
                                        input logic fin);
        t_list_result r;
        r.value  = v;
        r.status = st;
        r.last   = fin;
        expected_results.push_back(r);
    endfunction

    // Updates the shadow list and queues the results one transaction produces.
    function automatic void predict_list_op(input logic [1:0] op, input logic [31:0] val);
        int hit;
        hit = -1;
        case (op)
            olad_pkg::CMD_APPEND: begin
                if (held_values.size() >= LIST_DEPTH) begin
                    push_result(val, olad_pkg::ST_FULL, 1'b1);
                end else begin
                    held_values.push_back(val);
                    push_result(val, olad_pkg::ST_DONE, 1'b1);
                end
            end
            olad_pkg::CMD_DELETE: begin
                if (held_values.size() == 0) begin
                    push_result(val, olad_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < held_values.size(); i++) begin
                        if (hit < 0 && held_values[i] === val) hit = i;
                    end
                    if (hit >= 0) begin
                        held_values.delete(hit);
                        push_result(val, olad_pkg::ST_DONE, 1'b1);
                    end else begin
                        push_result(val, olad_pkg::ST_NOT_FOUND, 1'b1);
                    end
                end
            end
            olad_pkg::CMD_DUMP: begin
                if (held_values.size() == 0) begin
                    push_result(val, olad_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < held_values.size(); i++) begin
                        push_result(held_values[i], olad_pkg::ST_ENTRY,
                                    (i == held_values.size() - 1));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [31:0] val);
        while (sender_idles && $urandom_range(99) < 11) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= op;
        i_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_list_op(op, val);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result value %h status %0d last %b",
                                        o_item_value, o_status, o_last));
            end else begin
                want = expected_results.pop_front();
                if (o_item_value !== want.value || o_status !== want.status
                        || o_last !== want.last) begin
                    note_mismatch($sformatf(
                        "expected value %h status %0d last %b, got %h %0d %b",
                        want.value, want.status, want.last,
                        o_item_value, o_status, o_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [31:0] pool_value();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 32'h0000_0000;
            1: v = 32'h0000_0001;
            2: v = 32'hffff_ffff;
            3: v = 32'h8000_0000;
            4: v = 32'h7fff_ffff;
            5: v = 32'h8000_0001;
            6: v = 32'hffff_fffe;
            default: v = 32'h1234_5678;
        endcase
        return v;
    endfunction

    task automatic test_empty_list();
        send_item(olad_pkg::CMD_DUMP, 32'h0000_0000);
        send_item(olad_pkg::CMD_DELETE, 32'h8000_0000);
        send_item(CMD_UNUSED, 32'h7fff_ffff);
        send_item(olad_pkg::CMD_APPEND, 32'h7fff_ffff);
        send_item(olad_pkg::CMD_DELETE, 32'h7fff_ffff);
        send_item(olad_pkg::CMD_DUMP, 32'hffff_ffff);
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        logic [31:0] fill [16];
        fill = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h7fff_ffff,
                 32'h8000_0001, 32'hffff_fffe, 32'h1234_5678, 32'h0000_0000,
                 32'hdead_beef, 32'h0001_0000, 32'h7fff_fffe, 32'h8000_0000};
        for (int i = 0; i < LIST_DEPTH; i++) send_item(olad_pkg::CMD_APPEND, fill[i]);
        send_item(olad_pkg::CMD_APPEND, 32'h0000_0001);
        send_item(olad_pkg::CMD_DUMP, 32'h0);
        wait_drained();
    endtask

    task automatic test_delete_order();
        send_item(olad_pkg::CMD_DELETE, 32'h1357_9bdf);
        send_item(olad_pkg::CMD_DELETE, 32'h7fff_ffff);
        send_item(olad_pkg::CMD_DELETE, 32'h8000_0000);
        send_item(olad_pkg::CMD_DUMP, 32'h0);
        wait_drained();
    endtask

    task automatic random_phase(input int unsigned n_items, input int unsigned append_pct);
        int unsigned sent;
        int unsigned r;
        logic [1:0]  op;
        logic [31:0] val;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3) op = CMD_UNUSED;
            else if (r < 3 + append_pct) op = olad_pkg::CMD_APPEND;
            else if (r < 3 + append_pct + (97 - append_pct) * 3 / 4) op = olad_pkg::CMD_DELETE;
            else op = olad_pkg::CMD_DUMP;
            r = $urandom_range(99);
            if (op == olad_pkg::CMD_DELETE && held_values.size() != 0 && r < 60)
                val = held_values[$urandom_range(held_values.size() - 1)];
            else if (op != olad_pkg::CMD_DUMP && r < 80)
                val = pool_value();
            else
                val = $urandom;
            send_item(op, val);
            if (op != CMD_UNUSED) sent++;
        end
    endtask

    task automatic test_random_traffic();
        random_phase(150, 60);
        sender_idles = 1'b0;
        random_phase(100, 40);
        wait_drained();
        sender_idles = 1'b1;
        random_phase(150, 50);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_fill_to_capacity();
        test_delete_order();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ ordered_list_append_delete.f @@
hdl/olad_pkg.sv
hdl/olad_ctrl.sv
hdl/olad_dp.sv
hdl/ordered_list_append_delete.sv
sim/ordered_list_append_delete_test.sv
